### src/tcpf_pkg.sv
package tcpf_pkg;

	localparam logic [3:0] ST_CLOSED     = 4'd0;
	localparam logic [3:0] ST_LISTEN     = 4'd1;
	localparam logic [3:0] ST_SYN_SENT   = 4'd2;
	localparam logic [3:0] ST_SYN_RCVD   = 4'd3;
	localparam logic [3:0] ST_ESTAB      = 4'd4;
	localparam logic [3:0] ST_FIN_WAIT1  = 4'd5;
	localparam logic [3:0] ST_FIN_WAIT2  = 4'd6;
	localparam logic [3:0] ST_CLOSE_WAIT = 4'd7;
	localparam logic [3:0] ST_CLOSING    = 4'd8;
	localparam logic [3:0] ST_LAST_ACK   = 4'd9;
	localparam logic [3:0] ST_TIME_WAIT  = 4'd10;

	localparam logic KIND_EVENT   = 1'b0;
	localparam logic KIND_SEGMENT = 1'b1;

	localparam logic [1:0] EV_LISTEN  = 2'd0;
	localparam logic [1:0] EV_CONNECT = 2'd1;
	localparam logic [1:0] EV_CLOSE   = 2'd2;
	localparam logic [1:0] EV_SEND    = 2'd3;

	localparam logic [2:0] VERD_NONE     = 3'd0;
	localparam logic [2:0] VERD_ACCEPTED = 3'd1;
	localparam logic [2:0] VERD_DISCARD  = 3'd2;
	localparam logic [2:0] VERD_INVALID  = 3'd3;
	localparam logic [2:0] VERD_OUT_WIN  = 3'd4;

	localparam logic [2:0] SEND_NONE     = 3'd0;
	localparam logic [2:0] SEND_SYN      = 3'd1;
	localparam logic [2:0] SEND_SYNACK   = 3'd2;
	localparam logic [2:0] SEND_PURE_ACK = 3'd3;
	localparam logic [2:0] SEND_FIN      = 3'd4;
	localparam logic [2:0] SEND_RST      = 3'd5;
	localparam logic [2:0] SEND_DATA     = 3'd6;

	localparam logic [2:0] NOTE_NONE      = 3'd0;
	localparam logic [2:0] NOTE_LISTENING = 3'd1;
	localparam logic [2:0] NOTE_CLOSED    = 3'd2;
	localparam logic [2:0] NOTE_NEW_CONN  = 3'd3;
	localparam logic [2:0] NOTE_CONNECTED = 3'd4;
	localparam logic [2:0] NOTE_TIME_WAIT = 3'd5;
	localparam logic [2:0] NOTE_ACKED     = 3'd6;

	localparam logic [15:0] DEFAULT_WINDOW = 16'd1024;

	localparam logic [1:0] ADDR_SEND_WINDOW = 2'd0;

	typedef struct packed {
		logic        kind;
		logic [1:0]  user_event;
		logic        flag_syn;
		logic        flag_ack;
		logic        flag_fin;
		logic [31:0] seg_seq;
		logic [31:0] seg_ack;
		logic [15:0] seg_window;
		logic [15:0] seg_length;
		logic [31:0] initial_seq;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  verdict;
		logic [2:0]  send_kind;
		logic [31:0] out_seq;
		logic [31:0] out_ack;
		logic [15:0] out_wnd;
		logic [2:0]  notify;
		logic [31:0] acked_to;
		logic [3:0]  conn_state_out;
	} out_item_t;

	typedef struct packed {
		logic [3:0]  conn_state;
		logic [31:0] send_unacked;
		logic [31:0] send_next;
		logic [31:0] recv_next;
		logic [15:0] send_window;
	} conn_regs_t;

endpackage

### src/tcpf_in_if.sv
interface tcpf_in_if;
	logic                valid;
	logic                ready;
	tcpf_pkg::in_item_t  item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

### src/tcpf_out_if.sv
interface tcpf_out_if;
	logic                valid;
	logic                ready;
	tcpf_pkg::out_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

### src/tcpf_step.sv
module tcpf_step (
	input  tcpf_pkg::in_item_t  item,
	input  tcpf_pkg::conn_regs_t cur,
	output tcpf_pkg::conn_regs_t nxt,
	output tcpf_pkg::out_item_t  res
);
	import tcpf_pkg::*;

	logic        is_ack;
	logic        is_syn;
	logic        is_synack;
	logic        is_fin;
	logic        in_win;
	logic        ack_eq_nxt;
	logic [31:0] seq_inc;
	logic [31:0] rcv_inc;
	logic [31:0] seq_len;
	logic [31:0] send_end;
	logic [31:0] send_lim;

	assign is_ack     = item.flag_ack & ~item.flag_syn & ~item.flag_fin;
	assign is_syn     = item.flag_syn & ~item.flag_ack & ~item.flag_fin;
	assign is_synack  = item.flag_syn & item.flag_ack & ~item.flag_fin;
	assign is_fin     = item.flag_fin & item.flag_ack & ~item.flag_syn;
	assign in_win     = (item.seg_ack <= cur.send_next) && (item.seg_seq == cur.recv_next);
	assign ack_eq_nxt = item.seg_ack == cur.send_next;
	assign seq_inc    = item.seg_seq + 32'd1;
	assign rcv_inc    = cur.recv_next + 32'd1;
	assign seq_len    = item.seg_seq + 32'(item.seg_length);
	assign send_end   = cur.send_next + 32'(item.seg_length);
	assign send_lim   = cur.send_unacked + 32'(cur.send_window);

	always_comb begin
		nxt = cur;
		res = '0;
		if (item.kind == KIND_EVENT) begin
			unique case (cur.conn_state)
				ST_CLOSED: begin
					unique case (item.user_event)
						EV_LISTEN: begin
							res.notify = NOTE_LISTENING;
							nxt.conn_state = ST_LISTEN;
						end
						EV_CONNECT: begin
							nxt.send_unacked = item.initial_seq;
							nxt.send_next = item.initial_seq + 32'd1;
							nxt.send_window = DEFAULT_WINDOW;
							res.send_kind = SEND_SYN;
							res.out_seq = item.initial_seq;
							res.out_wnd = DEFAULT_WINDOW;
							nxt.conn_state = ST_SYN_SENT;
						end
						EV_CLOSE: res.notify = NOTE_CLOSED;
						default: res.verdict = VERD_INVALID;
					endcase
				end
				ST_LISTEN: begin
					if (item.user_event == EV_CLOSE) begin
						res.notify = NOTE_CLOSED;
						nxt.conn_state = ST_CLOSED;
					end else begin
						res.verdict = VERD_INVALID;
					end
				end
				ST_SYN_RCVD, ST_CLOSE_WAIT: begin
					if (item.user_event == EV_CLOSE) begin
						res.send_kind = SEND_FIN;
						res.out_seq = cur.send_next;
						res.out_ack = cur.recv_next;
						res.out_wnd = cur.send_window;
						nxt.send_next = cur.send_next + 32'd1;
						nxt.conn_state = (cur.conn_state == ST_SYN_RCVD) ? ST_FIN_WAIT1 :
							ST_LAST_ACK;
					end else begin
						res.verdict = VERD_INVALID;
					end
				end
				ST_ESTAB: begin
					if (item.user_event == EV_SEND) begin
						if (send_end >= send_lim) begin
							res.verdict = VERD_OUT_WIN;
							res.out_wnd = cur.send_window;
						end else begin
							res.send_kind = SEND_DATA;
							res.out_seq = cur.send_next;
							res.out_ack = cur.recv_next;
							res.out_wnd = cur.send_window;
							nxt.send_next = send_end;
						end
					end else if (item.user_event == EV_CLOSE) begin
						res.send_kind = SEND_FIN;
						res.out_seq = cur.send_next;
						res.out_ack = cur.recv_next;
						res.out_wnd = cur.send_window;
						nxt.send_next = cur.send_next + 32'd1;
						nxt.conn_state = ST_FIN_WAIT1;
					end else begin
						res.verdict = VERD_INVALID;
					end
				end
				default: res.verdict = VERD_INVALID;
			endcase
		end else begin
			res.verdict = VERD_DISCARD;
			unique case (cur.conn_state)
				ST_CLOSED: begin
					if (is_syn) begin
						nxt.send_unacked = item.initial_seq;
						nxt.send_next = item.initial_seq + 32'd1;
						nxt.send_window = DEFAULT_WINDOW;
						nxt.recv_next = seq_inc;
						res.verdict = VERD_ACCEPTED;
						res.send_kind = SEND_SYNACK;
						res.out_seq = item.initial_seq;
						res.out_ack = seq_inc;
						res.out_wnd = DEFAULT_WINDOW;
						nxt.conn_state = ST_SYN_RCVD;
					end else begin
						res.send_kind = SEND_RST;
						res.out_seq = item.seg_ack;
					end
				end
				ST_LISTEN: begin
					if (item.flag_syn && !item.flag_ack) begin
						res.verdict = VERD_ACCEPTED;
						res.notify = NOTE_NEW_CONN;
					end
				end
				ST_SYN_RCVD: begin
					if (is_ack && ack_eq_nxt) begin
						nxt.send_unacked = item.seg_ack;
						res.verdict = VERD_ACCEPTED;
						res.notify = NOTE_CONNECTED;
						nxt.conn_state = ST_ESTAB;
					end
				end
				ST_SYN_SENT: begin
					if (is_syn) begin
						nxt.recv_next = seq_inc;
						res.verdict = VERD_ACCEPTED;
						res.send_kind = SEND_PURE_ACK;
						res.out_seq = cur.send_next - 32'd1;
						res.out_ack = seq_inc;
						res.out_wnd = cur.send_window;
						nxt.conn_state = ST_SYN_RCVD;
					end else if (is_synack && ack_eq_nxt) begin
						nxt.send_unacked = item.seg_ack;
						nxt.recv_next = seq_inc;
						res.verdict = VERD_ACCEPTED;
						res.send_kind = SEND_PURE_ACK;
						res.out_seq = cur.send_next;
						res.out_ack = seq_inc;
						res.out_wnd = cur.send_window;
						res.notify = NOTE_CONNECTED;
						nxt.conn_state = ST_ESTAB;
					end
				end
				ST_ESTAB: begin
					if (is_ack && in_win) begin
						if (item.seg_ack > cur.send_unacked) begin
							nxt.send_unacked = item.seg_ack;
						end
						nxt.recv_next = seq_len;
						res.verdict = VERD_ACCEPTED;
						res.notify = NOTE_ACKED;
						res.acked_to = item.seg_ack;
						if (item.seg_length != 16'd0) begin
							res.send_kind = SEND_PURE_ACK;
							res.out_seq = cur.send_next;
							res.out_ack = seq_len;
							res.out_wnd = cur.send_window;
						end
					end else if (is_fin && in_win) begin
						nxt.recv_next = rcv_inc;
						res.verdict = VERD_ACCEPTED;
						res.send_kind = SEND_PURE_ACK;
						res.out_seq = cur.send_next;
						res.out_ack = rcv_inc;
						res.out_wnd = cur.send_window;
						nxt.conn_state = ST_CLOSE_WAIT;
					end
				end
				ST_FIN_WAIT1: begin
					if (is_ack && in_win) begin
						res.verdict = VERD_ACCEPTED;
						if (ack_eq_nxt) begin
							nxt.conn_state = ST_FIN_WAIT2;
						end
					end else if (is_fin && in_win) begin
						nxt.recv_next = rcv_inc;
						res.verdict = VERD_ACCEPTED;
						res.send_kind = SEND_PURE_ACK;
						res.out_seq = cur.send_next;
						res.out_ack = rcv_inc;
						res.out_wnd = cur.send_window;
						if (ack_eq_nxt) begin
							res.notify = NOTE_TIME_WAIT;
							nxt.conn_state = ST_TIME_WAIT;
						end else begin
							nxt.conn_state = ST_CLOSING;
						end
					end
				end
				ST_FIN_WAIT2: begin
					if (is_fin && ack_eq_nxt && item.seg_seq == cur.recv_next) begin
						nxt.recv_next = seq_inc;
						res.verdict = VERD_ACCEPTED;
						res.send_kind = SEND_PURE_ACK;
						res.out_seq = cur.send_next;
						res.out_ack = seq_inc;
						res.out_wnd = cur.send_window;
						res.notify = NOTE_TIME_WAIT;
						nxt.conn_state = ST_TIME_WAIT;
					end
				end
				ST_CLOSING, ST_LAST_ACK: begin
					if (is_ack && item.seg_ack >= cur.send_unacked &&
						item.seg_seq == cur.recv_next) begin
						nxt.send_unacked = item.seg_ack;
						res.verdict = VERD_ACCEPTED;
						if (ack_eq_nxt) begin
							if (cur.conn_state == ST_CLOSING) begin
								res.notify = NOTE_TIME_WAIT;
								nxt.conn_state = ST_TIME_WAIT;
							end else begin
								res.notify = NOTE_CLOSED;
								nxt.conn_state = ST_CLOSED;
							end
						end
					end
				end
				default: ;
			endcase
		end
		res.conn_state_out = nxt.conn_state;
	end

endmodule

### src/tcp_connection_fsm_unit.sv
// channel  | dir | word                                   | handshake
// in_ch    | in  | user event or received segment          | valid/ready
// out_ch   | out | verdict, segment to send, notify, state | valid/ready
// apb      | in  | send_window at byte address 0           | psel/penable
//
// One word per cycle sustained while the output is not stalled; a word passes
// through the input register and then the result register before its result
// is valid at the output. The state update and the result are computed in one
// pass of logic between these two registers.
// arst_n clears both stages, the connection state and pointers; send_window
// returns to 1024. A stalled output holds the result register, the input
// register fills behind it, and then input ready drops.
module tcp_connection_fsm_unit (
	input  logic        clk,
	input  logic        arst_n,
	tcpf_in_if.sink     in_ch,
	tcpf_out_if.source  out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import tcpf_pkg::*;

	in_item_t   item_s1;
	logic       valid_s1;
	out_item_t  res_s2;
	logic       valid_s2;
	conn_regs_t regs_q;
	conn_regs_t regs_nxt;
	out_item_t  res;
	logic       advance;
	logic       in_take;
	logic       cfg_wr;

	assign advance      = valid_s1 & (~valid_s2 | out_ch.ready);
	assign in_ch.ready  = ~valid_s1 | advance;
	assign in_take      = in_ch.valid & in_ch.ready;
	assign out_ch.valid = valid_s2;
	assign out_ch.item  = res_s2;
	assign pready       = 1'b1;
	assign cfg_wr       = psel & penable & pwrite & (paddr == ADDR_SEND_WINDOW);
	assign prdata       = (paddr == ADDR_SEND_WINDOW) ? {16'd0, regs_q.send_window} : 32'd0;

	tcpf_step u_step (
		.item (item_s1),
		.cur  (regs_q),
		.nxt  (regs_nxt),
		.res  (res)
	);

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1 <= in_ch.item;
		end
		if (advance) begin
			res_s2 <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			regs_q.conn_state <= ST_CLOSED;
			regs_q.send_unacked <= 32'd0;
			regs_q.send_next <= 32'd0;
			regs_q.recv_next <= 32'd0;
			regs_q.send_window <= DEFAULT_WINDOW;
		end else begin
			valid_s1 <= in_take | (valid_s1 & ~advance);
			valid_s2 <= advance | (valid_s2 & ~out_ch.ready);
			if (advance) begin
				regs_q <= regs_nxt;
			end else if (cfg_wr) begin
				regs_q.send_window <= pwdata[15:0];
			end
		end
	end

endmodule

### src/tcpf_checker.sv
module tcpf_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input tcpf_pkg::out_item_t out_item
);
	import tcpf_pkg::*;

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
	else $error("stalled result word changed or dropped");

	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
	else $error("input stalled with empty output");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.verdict == VERD_INVALID |->
		out_item.send_kind == SEND_NONE && out_item.notify == NOTE_NONE)
	else $error("invalid operation produced a segment or notification");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.send_kind == SEND_RST |->
		out_item.conn_state_out == ST_CLOSED && out_item.verdict == VERD_DISCARD)
	else $error("reset segment outside closed state");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.conn_state_out <= ST_TIME_WAIT)
	else $error("unreachable state reported");

endmodule

bind tcp_connection_fsm_unit tcpf_checker u_tcpf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_item  (out_ch.item)
);

### tb/sv/tcp_connection_fsm_unit_tb.sv
module tcp_connection_fsm_unit_tb;
	import tcpf_pkg::*;

	typedef struct packed {
		logic [3:0]  conn;
		logic [31:0] snd_una;
		logic [31:0] snd_nxt;
		logic [31:0] rcv_nxt;
		logic [15:0] peer_wnd;
		logic [15:0] snd_wnd;
	} tcb_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [1:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	tcpf_in_if  in_ch ();
	tcpf_out_if out_ch ();

	tcp_connection_fsm_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	in_item_t    pending_words[$];
	out_item_t   expected_results[$];
	out_item_t   want;
	tcb_t        plan_tcb;
	tcb_t        live_tcb;
	int unsigned src_idle;
	int unsigned sink_stall;
	int unsigned errors;
	int unsigned words_in;
	int unsigned results_checked;
	int unsigned windows_set;
	logic [15:0] states_seen;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic void put_seg(inout out_item_t r, input logic [2:0] k,
			input logic [31:0] s, input logic [31:0] a, input logic [15:0] wd);
		r.send_kind = k;
		r.out_seq = s;
		r.out_ack = a;
		r.out_wnd = wd;
	endfunction

	function automatic out_item_t conn_step(inout tcb_t m, input in_item_t w);
		out_item_t   r;
		logic        is_ack;
		logic        is_syn;
		logic        is_synack;
		logic        is_fin;
		logic        in_win;
		logic [31:0] lhs;
		logic [31:0] rhs;
		r = '0;
		if (w.kind == KIND_EVENT) begin
			case (m.conn)
				ST_CLOSED: begin
					if (w.user_event == EV_LISTEN) begin
						r.notify = NOTE_LISTENING;
						m.conn = ST_LISTEN;
					end else if (w.user_event == EV_CONNECT) begin
						m.snd_una = w.initial_seq;
						m.snd_nxt = w.initial_seq + 32'd1;
						m.snd_wnd = DEFAULT_WINDOW;
						put_seg(r, SEND_SYN, w.initial_seq, 32'd0, m.snd_wnd);
						m.conn = ST_SYN_SENT;
					end else if (w.user_event == EV_CLOSE) begin
						r.notify = NOTE_CLOSED;
					end else begin
						r.verdict = VERD_INVALID;
					end
				end
				ST_LISTEN: begin
					if (w.user_event == EV_CLOSE) begin
						r.notify = NOTE_CLOSED;
						m.conn = ST_CLOSED;
					end else begin
						r.verdict = VERD_INVALID;
					end
				end
				ST_SYN_RCVD, ST_CLOSE_WAIT: begin
					if (w.user_event == EV_CLOSE) begin
						put_seg(r, SEND_FIN, m.snd_nxt, m.rcv_nxt, m.snd_wnd);
						m.snd_nxt = m.snd_nxt + 32'd1;
						m.conn = (m.conn == ST_SYN_RCVD) ? ST_FIN_WAIT1 : ST_LAST_ACK;
					end else begin
						r.verdict = VERD_INVALID;
					end
				end
				ST_ESTAB: begin
					if (w.user_event == EV_SEND) begin
						lhs = m.snd_nxt + {16'h0, w.seg_length};
						rhs = m.snd_una + {16'h0, m.snd_wnd};
						if (lhs >= rhs) begin
							r.verdict = VERD_OUT_WIN;
							r.out_wnd = m.snd_wnd;
						end else begin
							put_seg(r, SEND_DATA, m.snd_nxt, m.rcv_nxt, m.snd_wnd);
							m.snd_nxt = lhs;
						end
					end else if (w.user_event == EV_CLOSE) begin
						put_seg(r, SEND_FIN, m.snd_nxt, m.rcv_nxt, m.snd_wnd);
						m.snd_nxt = m.snd_nxt + 32'd1;
						m.conn = ST_FIN_WAIT1;
					end else begin
						r.verdict = VERD_INVALID;
					end
				end
				default: begin
					r.verdict = VERD_INVALID;
				end
			endcase
		end else begin
			is_ack = w.flag_ack && !w.flag_syn && !w.flag_fin;
			is_syn = w.flag_syn && !w.flag_ack && !w.flag_fin;
			is_synack = w.flag_syn && w.flag_ack && !w.flag_fin;
			is_fin = w.flag_fin && w.flag_ack && !w.flag_syn;
			in_win = (w.seg_ack <= m.snd_nxt) && (w.seg_seq == m.rcv_nxt);
			r.verdict = VERD_DISCARD;
			case (m.conn)
				ST_CLOSED: begin
					if (is_syn) begin
						m.snd_una = w.initial_seq;
						m.snd_nxt = w.initial_seq + 32'd1;
						m.snd_wnd = DEFAULT_WINDOW;
						m.rcv_nxt = w.seg_seq + 32'd1;
						m.peer_wnd = w.seg_window;
						r.verdict = VERD_ACCEPTED;
						put_seg(r, SEND_SYNACK, w.initial_seq, m.rcv_nxt, m.snd_wnd);
						m.conn = ST_SYN_RCVD;
					end else begin
						put_seg(r, SEND_RST, w.seg_ack, 32'd0, 16'd0);
					end
				end
				ST_LISTEN: begin
					if (w.flag_syn && !w.flag_ack) begin
						r.verdict = VERD_ACCEPTED;
						r.notify = NOTE_NEW_CONN;
					end
				end
				ST_SYN_RCVD: begin
					if (is_ack && w.seg_ack == m.snd_nxt) begin
						m.snd_una = w.seg_ack;
						m.peer_wnd = w.seg_window;
						r.verdict = VERD_ACCEPTED;
						r.notify = NOTE_CONNECTED;
						m.conn = ST_ESTAB;
					end
				end
				ST_SYN_SENT: begin
					if (is_syn) begin
						m.rcv_nxt = w.seg_seq + 32'd1;
						m.peer_wnd = w.seg_window;
						r.verdict = VERD_ACCEPTED;
						put_seg(r, SEND_PURE_ACK, m.snd_nxt - 32'd1, m.rcv_nxt, m.snd_wnd);
						m.conn = ST_SYN_RCVD;
					end else if (is_synack && w.seg_ack == m.snd_nxt) begin
						m.snd_una = w.seg_ack;
						m.rcv_nxt = w.seg_seq + 32'd1;
						m.peer_wnd = w.seg_window;
						r.verdict = VERD_ACCEPTED;
						put_seg(r, SEND_PURE_ACK, m.snd_nxt, m.rcv_nxt, m.snd_wnd);
						r.notify = NOTE_CONNECTED;
						m.conn = ST_ESTAB;
					end
				end
				ST_ESTAB: begin
					if (is_ack && in_win) begin
						if (w.seg_ack > m.snd_una)
							m.snd_una = w.seg_ack;
						m.rcv_nxt = w.seg_seq + {16'h0, w.seg_length};
						m.peer_wnd = w.seg_window;
						r.verdict = VERD_ACCEPTED;
						r.notify = NOTE_ACKED;
						r.acked_to = w.seg_ack;
						if (w.seg_length != 16'd0)
							put_seg(r, SEND_PURE_ACK, m.snd_nxt, m.rcv_nxt, m.snd_wnd);
					end else if (is_fin && in_win) begin
						m.peer_wnd = w.seg_window;
						m.rcv_nxt = m.rcv_nxt + 32'd1;
						r.verdict = VERD_ACCEPTED;
						put_seg(r, SEND_PURE_ACK, m.snd_nxt, m.rcv_nxt, m.snd_wnd);
						m.conn = ST_CLOSE_WAIT;
					end
				end
				ST_FIN_WAIT1: begin
					if (is_ack && in_win) begin
						r.verdict = VERD_ACCEPTED;
						if (w.seg_ack == m.snd_nxt)
							m.conn = ST_FIN_WAIT2;
					end else if (is_fin && in_win) begin
						m.peer_wnd = w.seg_window;
						m.rcv_nxt = m.rcv_nxt + 32'd1;
						r.verdict = VERD_ACCEPTED;
						put_seg(r, SEND_PURE_ACK, m.snd_nxt, m.rcv_nxt, m.snd_wnd);
						if (w.seg_ack == m.snd_nxt) begin
							r.notify = NOTE_TIME_WAIT;
							m.conn = ST_TIME_WAIT;
						end else begin
							m.conn = ST_CLOSING;
						end
					end
				end
				ST_FIN_WAIT2: begin
					if (is_fin && w.seg_ack == m.snd_nxt && w.seg_seq == m.rcv_nxt) begin
						m.rcv_nxt = w.seg_seq + 32'd1;
						m.peer_wnd = w.seg_window;
						r.verdict = VERD_ACCEPTED;
						put_seg(r, SEND_PURE_ACK, m.snd_nxt, m.rcv_nxt, m.snd_wnd);
						r.notify = NOTE_TIME_WAIT;
						m.conn = ST_TIME_WAIT;
					end
				end
				ST_CLOSING, ST_LAST_ACK: begin
					if (is_ack && w.seg_ack >= m.snd_una && w.seg_seq == m.rcv_nxt) begin
						m.snd_una = w.seg_ack;
						r.verdict = VERD_ACCEPTED;
						if (m.snd_nxt == w.seg_ack) begin
							if (m.conn == ST_CLOSING) begin
								r.notify = NOTE_TIME_WAIT;
								m.conn = ST_TIME_WAIT;
							end else begin
								r.notify = NOTE_CLOSED;
								m.conn = ST_CLOSED;
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
		r.conn_state_out = m.conn;
		return r;
	endfunction

	function automatic in_item_t rand_word();
		in_item_t w;
		w.kind = 1'($urandom);
		w.user_event = 2'($urandom);
		w.flag_syn = 1'($urandom);
		w.flag_ack = 1'($urandom);
		w.flag_fin = 1'($urandom);
		w.seg_seq = $urandom;
		w.seg_ack = $urandom;
		w.seg_window = 16'($urandom);
		w.seg_length = 16'($urandom);
		w.initial_seq = $urandom;
		if ($urandom_range(0, 7) == 0)
			w.initial_seq = 32'hFFFF_FFFF - $urandom_range(0, 2000);
		return w;
	endfunction

	function automatic in_item_t ev_word(input logic [1:0] ev, input logic [15:0] len,
			input logic [31:0] isn);
		in_item_t w;
		w = rand_word();
		w.kind = KIND_EVENT;
		w.user_event = ev;
		w.seg_length = len;
		w.initial_seq = isn;
		return w;
	endfunction

	function automatic in_item_t seg_word(input logic syn, input logic ackf, input logic fin,
			input logic [31:0] seq, input logic [31:0] ackn, input logic [15:0] wnd,
			input logic [15:0] len);
		in_item_t w;
		w = rand_word();
		w.kind = KIND_SEGMENT;
		w.flag_syn = syn;
		w.flag_ack = ackf;
		w.flag_fin = fin;
		w.seg_seq = seq;
		w.seg_ack = ackn;
		w.seg_window = wnd;
		w.seg_length = len;
		return w;
	endfunction

	function automatic logic [31:0] ack_between(input tcb_t m);
		logic [31:0] span;
		span = m.snd_nxt - m.snd_una;
		if (span > 32'd100000)
			return m.snd_nxt;
		return m.snd_una + $urandom_range(0, span);
	endfunction

	// end_game lets the connection close actively; afterwards it can only reach time wait
	function automatic in_item_t pick_word(input tcb_t m, input bit end_game);
		in_item_t    w;
		int unsigned p;
		logic [15:0] len;
		w = rand_word();
		p = $urandom_range(0, 99);
		if (p < 12) begin
			if (!end_game && w.kind == KIND_EVENT && w.user_event == EV_CLOSE
					&& (m.conn == ST_ESTAB || m.conn == ST_SYN_RCVD))
				w.user_event = EV_SEND;
			return w;
		end
		p = $urandom_range(0, 99);
		len = ($urandom_range(0, 3) != 0) ? 16'($urandom_range(0, 400)) : w.seg_length;
		case (m.conn)
			ST_CLOSED: begin
				if (p < 40)
					w = ev_word(EV_CONNECT, len, w.initial_seq);
				else if (p < 75)
					w = seg_word(1'b1, 1'b0, 1'b0, w.seg_seq, w.seg_ack, w.seg_window, len);
				else if (p < 92)
					w = ev_word(EV_LISTEN, len, w.initial_seq);
				else
					w = ev_word(EV_CLOSE, len, w.initial_seq);
			end
			ST_LISTEN: begin
				if (p < 55)
					w = seg_word(1'b1, 1'b0, w.flag_fin, w.seg_seq, w.seg_ack, w.seg_window, len);
				else if (p < 70)
					w = seg_word(1'b1, 1'b1, 1'b0, w.seg_seq, w.seg_ack, w.seg_window, len);
				else
					w = ev_word(EV_CLOSE, len, w.initial_seq);
			end
			ST_SYN_SENT: begin
				if (p < 60)
					w = seg_word(1'b1, 1'b1, 1'b0, w.seg_seq, m.snd_nxt, w.seg_window, len);
				else if (p < 80)
					w = seg_word(1'b1, 1'b0, 1'b0, w.seg_seq, w.seg_ack, w.seg_window, len);
				else
					w = seg_word(1'b1, 1'b1, 1'b0, w.seg_seq, w.seg_ack, w.seg_window, len);
			end
			ST_SYN_RCVD: begin
				if (p < 75)
					w = seg_word(1'b0, 1'b1, 1'b0, w.seg_seq, m.snd_nxt, w.seg_window, len);
				else if (end_game && p >= 90)
					w = ev_word(EV_CLOSE, len, w.initial_seq);
				else
					w = seg_word(1'b0, 1'b1, 1'b0, w.seg_seq, w.seg_ack, w.seg_window, len);
			end
			ST_ESTAB: begin
				if (p < 40)
					w = ev_word(EV_SEND, len, w.initial_seq);
				else if (p < 72)
					w = seg_word(1'b0, 1'b1, 1'b0, m.rcv_nxt, ack_between(m), w.seg_window, len);
				else if (p < 82)
					w = seg_word(1'b0, 1'b1, 1'b0, m.rcv_nxt + 32'd1, ack_between(m),
						w.seg_window, len);
				else if (end_game && p >= 90)
					w = ev_word(EV_CLOSE, len, w.initial_seq);
				else
					w = seg_word(1'b0, 1'b1, 1'b1, m.rcv_nxt, ack_between(m), w.seg_window, len);
			end
			ST_CLOSE_WAIT: begin
				if (p < 60)
					w = ev_word(EV_CLOSE, len, w.initial_seq);
				else if (p < 80)
					w = ev_word(EV_SEND, len, w.initial_seq);
				else
					w = seg_word(1'b0, 1'b1, 1'b0, m.rcv_nxt, ack_between(m), w.seg_window, len);
			end
			ST_FIN_WAIT1: begin
				if (p < 35)
					w = seg_word(1'b0, 1'b1, 1'b0, m.rcv_nxt, m.snd_una, w.seg_window, len);
				else if (p < 60)
					w = seg_word(1'b0, 1'b1, 1'b0, m.rcv_nxt, m.snd_nxt, w.seg_window, len);
				else if (p < 80)
					w = seg_word(1'b0, 1'b1, 1'b1, m.rcv_nxt, m.snd_nxt, w.seg_window, len);
				else
					w = seg_word(1'b0, 1'b1, 1'b1, m.rcv_nxt, m.snd_nxt - 32'd1, w.seg_window, len);
			end
			ST_FIN_WAIT2: begin
				if (p < 50)
					w = seg_word(1'b0, 1'b1, 1'b1, m.rcv_nxt, m.snd_nxt, w.seg_window, len);
				else
					w = seg_word(1'b0, 1'b1, 1'b0, m.rcv_nxt, ack_between(m), w.seg_window, len);
			end
			ST_CLOSING, ST_LAST_ACK: begin
				if (p < 55)
					w = seg_word(1'b0, 1'b1, 1'b0, m.rcv_nxt, m.snd_nxt, w.seg_window, len);
				else if (p < 80)
					w = seg_word(1'b0, 1'b1, 1'b0, m.rcv_nxt, m.snd_una, w.seg_window, len);
				else
					w = seg_word(1'b0, 1'b1, 1'b0, m.rcv_nxt, w.seg_ack, w.seg_window, len);
			end
			default: begin
			end
		endcase
		return w;
	endfunction

	task automatic queue_word(input in_item_t w);
		void'(conn_step(plan_tcb, w));
		pending_words.push_back(w);
	endtask

	task automatic run_burst(input int unsigned n, input bit end_game);
		repeat (n)
			queue_word(pick_word(plan_tcb, end_game));
	endtask

	task automatic drain();
		@(posedge clk);
		while (pending_words.size() != 0 || in_ch.valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_window(input logic [15:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_SEND_WINDOW;
		pwdata <= {16'h0, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		plan_tcb.snd_wnd = v;
		live_tcb.snd_wnd = v;
		windows_set++;
	endtask

	task automatic check_field(input string what, input logic [31:0] exp_v,
			input logic [31:0] got_v);
		if (got_v !== exp_v) begin
			$display("%0t: %s expected %h got %h", $time, what, exp_v, got_v);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) begin
				expected_results.push_back(conn_step(live_tcb, in_ch.item));
				words_in++;
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (pending_words.size() != 0 && $urandom_range(0, 99) >= src_idle) begin
					in_ch.valid <= 1'b1;
					in_ch.item <= pending_words.pop_front();
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: expected nothing got %h", $time, out_ch.item);
					errors++;
				end else begin
					want = expected_results.pop_front();
					check_field("verdict", 32'(want.verdict), 32'(out_ch.item.verdict));
					check_field("send_kind", 32'(want.send_kind),
						32'(out_ch.item.send_kind));
					check_field("out_seq", want.out_seq, out_ch.item.out_seq);
					check_field("out_ack", want.out_ack, out_ch.item.out_ack);
					check_field("out_wnd", 32'(want.out_wnd), 32'(out_ch.item.out_wnd));
					check_field("notify", 32'(want.notify), 32'(out_ch.item.notify));
					check_field("acked_to", want.acked_to, out_ch.item.acked_to);
					check_field("conn_state_out", 32'(want.conn_state_out),
						32'(out_ch.item.conn_state_out));
					results_checked++;
				end
				states_seen[out_ch.item.conn_state_out] = 1'b1;
			end
			out_ch.ready <= ($urandom_range(0, 99) >= sink_stall);
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = ADDR_SEND_WINDOW;
		pwdata = 32'h0;
		in_ch.valid = 1'b0;
		in_ch.item = '0;
		out_ch.ready = 1'b0;
		src_idle = 38;
		sink_stall = 53;
		errors = 0;
		words_in = 0;
		results_checked = 0;
		windows_set = 0;
		states_seen = '0;
		plan_tcb = '0;
		plan_tcb.snd_wnd = DEFAULT_WINDOW;
		live_tcb = plan_tcb;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		queue_word(ev_word(EV_CLOSE, 16'h0, 32'h0));
		queue_word(ev_word(EV_SEND, 16'hFFFF, 32'hFFFF_FFFF));
		queue_word(seg_word(1'b0, 1'b1, 1'b0, 32'h0, 32'hFFFF_FFFF, 16'h0, 16'h0));
		queue_word(seg_word(1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'h0, 16'hFFFF, 16'hFFFF));
		queue_word(ev_word(EV_LISTEN, 16'h0, 32'h0));
		queue_word(ev_word(EV_LISTEN, 16'h0, 32'h0));
		queue_word(seg_word(1'b1, 1'b0, 1'b0, $urandom, 32'h0, 16'd100, 16'h0));
		queue_word(seg_word(1'b1, 1'b1, 1'b0, $urandom, $urandom, 16'd100, 16'h0));
		queue_word(ev_word(EV_CLOSE, 16'h0, 32'h0));
		// passive open with every pointer wrapping through zero
		queue_word(seg_word(1'b1, 1'b0, 1'b0, 32'hFFFF_FFFF, 32'h0, 16'hFFFF, 16'h0)
			| in_item_t'({32'hFFFF_FFFF}));
		queue_word(seg_word(1'b0, 1'b1, 1'b0, plan_tcb.rcv_nxt, plan_tcb.snd_nxt + 32'd1,
			16'h0, 16'h0));
		queue_word(seg_word(1'b0, 1'b1, 1'b0, plan_tcb.rcv_nxt, plan_tcb.snd_nxt,
			16'h0, 16'h0));
		queue_word(ev_word(EV_SEND, 16'h0, 32'h0));
		queue_word(ev_word(EV_SEND, 16'hFFFF, 32'h0));
		queue_word(ev_word(EV_SEND, 16'd100, 32'h0));
		queue_word(seg_word(1'b0, 1'b1, 1'b0, plan_tcb.rcv_nxt, plan_tcb.snd_nxt,
			16'hFFFF, 16'hFFFF));
		queue_word(seg_word(1'b0, 1'b1, 1'b0, plan_tcb.rcv_nxt + 32'd1, plan_tcb.snd_nxt,
			16'h0, 16'h0));
		queue_word(ev_word(EV_CONNECT, 16'h0, 32'h0));
		queue_word(seg_word(1'b0, 1'b1, 1'b1, plan_tcb.rcv_nxt, plan_tcb.snd_nxt,
			16'd500, 16'h0));
		queue_word(ev_word(EV_SEND, 16'd10, 32'h0));
		queue_word(ev_word(EV_CLOSE, 16'h0, 32'h0));
		queue_word(seg_word(1'b0, 1'b1, 1'b0, plan_tcb.rcv_nxt, plan_tcb.snd_una,
			16'h0, 16'h0));
		queue_word(seg_word(1'b0, 1'b1, 1'b0, plan_tcb.rcv_nxt, plan_tcb.snd_nxt,
			16'h0, 16'h0));
		queue_word(ev_word(EV_CONNECT, 16'h0, 32'h0));
		queue_word(seg_word(1'b1, 1'b0, 1'b0, 32'h0, 32'h0, 16'h1234, 16'h0));
		queue_word(seg_word(1'b0, 1'b1, 1'b0, plan_tcb.rcv_nxt, plan_tcb.snd_nxt,
			16'h0, 16'h0));
		drain();

		write_window(16'hFFFF);
		run_burst(90, 1'b0);
		drain();
		write_window(16'h0000);
		run_burst(90, 1'b0);
		drain();

		src_idle = 53;
		sink_stall = 38;
		write_window(16'($urandom));
		run_burst(90, 1'b0);
		drain();
		write_window(16'h0001);
		run_burst(90, 1'b0);
		drain();

		src_idle = 0;
		sink_stall = 0;
		write_window(16'($urandom_range(900, 1100)));
		run_burst(90, 1'b0);
		drain();
		write_window(16'($urandom));
		run_burst(100, 1'b1);
		drain();

		$display("tcp_connection_fsm_unit_tb: %0d words driven, %0d results compared,",
			words_in, results_checked);
		$display("tcp_connection_fsm_unit_tb: %0d window writes, %0d of 11 states observed",
			windows_set, $countones(states_seen));
		if (errors == 0)
			$display("tcp_connection_fsm_unit_tb: clean");
		else
			$display("tcp_connection_fsm_unit_tb: errors");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("tcp_connection_fsm_unit_tb: errors");
		$finish;
	end

endmodule
